FILE: design/mec_pkg.sv
// shared types, widths and fixed-point constants for the escape counter
`default_nettype none

package mec_pkg;

  localparam int C_W            = 32;
  localparam int FRAC_BITS      = 28;
  localparam int DEF_ITER_WIDTH = 16;
  localparam int MAX_ITER_RESET = 256;

  // operand magnitudes stay below 256.0, so eight integer bits are enough
  localparam int MAG_W  = FRAC_BITS + 8;
  localparam int HALF_W = MAG_W / 2;
  localparam int HI_W   = MAG_W - HALF_W;
  localparam int PP_W   = MAG_W + HI_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int VAL_W  = PROD_W - FRAC_BITS + 2;

  localparam logic signed [VAL_W-1:0] FIX_ONE       = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] FIX_FOUR      = VAL_W'(4) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] FIX_QUARTER   = VAL_W'(1) << (FRAC_BITS - 2);
  localparam logic signed [VAL_W-1:0] FIX_SIXTEENTH = VAL_W'(1) << (FRAC_BITS - 4);

  typedef enum logic [1:0] {
    MS_CARD_SQ,
    MS_CARD_PROD,
    MS_ITER
  } mul_sel_t;

  typedef struct packed {
    logic     load_pt;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     card_sum;
    logic     n_to_max;
    logic     loop_init;
    logic     iter_step;
    logic     out_load;
  } mec_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic in_set;
    logic keep_going;
  } mec_sts_t;

endpackage

`default_nettype wire

FILE: design/mec_ifs.sv
// point and count channel interfaces
`default_nettype none

interface mec_point_if import mec_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic signed [C_W-1:0] c_real;
  logic signed [C_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface mec_count_if import mec_pkg::*; #(
  parameter int ITER_WIDTH = DEF_ITER_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [ITER_WIDTH-1:0] iter_count;

  modport source (output valid, output iter_count, input ready);
  modport sink (input valid, input iter_count, output ready);
endinterface

`default_nettype wire

FILE: design/mec_mul.sv
// multi-cycle signed fixed-point multiplier, truncates toward zero
`default_nettype none

module mec_mul import mec_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    dbl,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output logic                    done,
  output logic signed [VAL_W-1:0] res
);

  logic signed [VAL_W-1:0] a_abs;
  logic signed [VAL_W-1:0] b_abs;
  logic [MAG_W-1:0]        a_mag;
  logic [MAG_W-1:0]        b_mag;
  logic                    neg;
  logic                    dbl_q;
  logic                    ph_lo;
  logic                    ph_hi;
  logic                    ph_post;
  logic [HI_W-1:0]         b_part;
  logic [PP_W-1:0]         pp;
  logic [PP_W-1:0]         acc;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       prod_shr;
  logic signed [VAL_W-1:0] res_mag;

  assign a_abs    = a[VAL_W-1] ? -a : a;
  assign b_abs    = b[VAL_W-1] ? -b : b;
  assign b_part   = ph_hi ? b_mag[MAG_W-1:HALF_W] : HI_W'(b_mag[HALF_W-1:0]);
  assign pp       = PP_W'(a_mag) * PP_W'(b_part);
  // cross term keeps one more bit before truncation
  assign prod_shr = dbl_q ? (prod >> (FRAC_BITS - 1)) : (prod >> FRAC_BITS);
  assign res_mag  = VAL_W'(prod_shr);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_lo   <= 1'b0;
      ph_hi   <= 1'b0;
      ph_post <= 1'b0;
      done    <= 1'b0;
    end else begin
      ph_lo   <= start;
      ph_hi   <= ph_lo;
      ph_post <= ph_hi;
      done    <= ph_post;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= a_abs[MAG_W-1:0];
      b_mag <= b_abs[MAG_W-1:0];
      neg   <= a[VAL_W-1] ^ b[VAL_W-1];
      dbl_q <= dbl;
    end
    if (ph_lo) begin
      acc <= pp;
    end
    if (ph_hi) begin
      prod <= PROD_W'(acc) + (PROD_W'(pp) << HALF_W);
    end
    if (ph_post) begin
      res <= neg ? -res_mag : res_mag;
    end
  end

endmodule

`default_nettype wire

FILE: design/mec_datapath.sv
// escape counter datapath: point registers, shortcut tests, z iteration
`default_nettype none

module mec_datapath import mec_pkg::*; #(
  parameter int ITER_WIDTH = DEF_ITER_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mec_cmd_t              cmd,
  output mec_sts_t              sts,
  input  logic signed [C_W-1:0] c_real,
  input  logic signed [C_W-1:0] c_imag,
  input  logic                  cfg_we,
  input  logic [ITER_WIDTH-1:0] cfg_wdata,
  output logic [ITER_WIDTH-1:0] iter_count
);

  logic [ITER_WIDTH-1:0]   limit;
  logic [ITER_WIDTH-1:0]   n;
  logic signed [VAL_W-1:0] cr;
  logic signed [VAL_W-1:0] ci;
  logic signed [VAL_W-1:0] x;
  logic signed [VAL_W-1:0] t;
  logic signed [VAL_W-1:0] q;
  logic signed [VAL_W-1:0] qx;
  logic signed [VAL_W-1:0] y2q;
  logic                    bulb;
  logic signed [VAL_W-1:0] r;
  logic signed [VAL_W-1:0] i;
  logic signed [VAL_W-1:0] cr_ext;
  logic signed [VAL_W-1:0] ci_ext;
  logic signed [VAL_W:0]   mag2;
  logic signed [VAL_W:0]   bulb_sum;

  logic signed [VAL_W-1:0] m0_a;
  logic signed [VAL_W-1:0] m0_b;
  logic signed [VAL_W-1:0] m1_a;
  logic signed [VAL_W-1:0] m2_a;
  logic                    m0_dbl;
  logic                    m0_done;
  logic                    m1_done;
  logic                    m2_done;
  logic signed [VAL_W-1:0] m0_res;
  logic signed [VAL_W-1:0] m1_res;
  logic signed [VAL_W-1:0] m2_res;

  assign cr_ext = VAL_W'(c_real);
  assign ci_ext = VAL_W'(c_imag);

  always_comb begin
    m0_a   = r;
    m0_b   = i;
    m1_a   = r;
    m2_a   = i;
    m0_dbl = 1'b1;
    case (cmd.mul_sel)
      MS_CARD_SQ: begin
        m0_a   = x;
        m0_b   = x;
        m1_a   = ci;
        m2_a   = t;
        m0_dbl = 1'b0;
      end
      MS_CARD_PROD: begin
        m0_a   = q;
        m0_b   = qx;
        m0_dbl = 1'b0;
      end
      MS_ITER: begin
        m0_a   = r;
        m0_b   = i;
        m0_dbl = 1'b1;
      end
      default: begin
        m0_a   = r;
        m0_b   = i;
        m0_dbl = 1'b1;
      end
    endcase
  end

  // m0: x^2, cardioid product or 2ri; m1: ci^2 or r^2; m2: (cr+1)^2 or i^2
  mec_mul u_mul0 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .dbl   (m0_dbl),
    .a     (m0_a),
    .b     (m0_b),
    .done  (m0_done),
    .res   (m0_res)
  );

  mec_mul u_mul1 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .dbl   (1'b0),
    .a     (m1_a),
    .b     (m1_a),
    .done  (m1_done),
    .res   (m1_res)
  );

  mec_mul u_mul2 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .dbl   (1'b0),
    .a     (m2_a),
    .b     (m2_a),
    .done  (m2_done),
    .res   (m2_res)
  );

  assign mag2     = (VAL_W+1)'(m1_res) + (VAL_W+1)'(m2_res);
  assign bulb_sum = (VAL_W+1)'(m2_res) + (VAL_W+1)'(m1_res);

  assign sts.mul_done   = m0_done & m1_done & m2_done;
  assign sts.in_set     = bulb | (m0_res < y2q);
  assign sts.keep_going = (mag2 <= (VAL_W+1)'(FIX_FOUR)) && (n < limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= ITER_WIDTH'(MAX_ITER_RESET);
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      cr <= cr_ext;
      ci <= ci_ext;
      x  <= cr_ext - FIX_QUARTER;
      t  <= cr_ext + FIX_ONE;
    end
    if (cmd.card_sum) begin
      q    <= m0_res + m1_res;
      qx   <= m0_res + m1_res + x;
      y2q  <= m1_res >>> 2;
      bulb <= bulb_sum < (VAL_W+1)'(FIX_SIXTEENTH);
    end
    if (cmd.loop_init) begin
      r <= '0;
      i <= '0;
      n <= '0;
    end
    if (cmd.n_to_max) begin
      n <= limit;
    end
    if (cmd.iter_step) begin
      i <= m0_res + ci;
      r <= m1_res - m2_res + cr;
      n <= n + 1'b1;
    end
    if (cmd.out_load) begin
      iter_count <= n;
    end
  end

endmodule

`default_nettype wire

FILE: design/mec_ctrl.sv
// escape counter controller state machine
`default_nettype none

module mec_ctrl import mec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output mec_cmd_t cmd,
  input  mec_sts_t sts
);

  typedef enum logic [3:0] {
    IDLE,
    CARD_SQ,
    CARD_SQ_WAIT,
    CARD_SUM,
    CARD_PROD,
    CARD_PROD_WAIT,
    CARD_CHECK,
    ITER_MUL,
    ITER_WAIT,
    ITER_TEST,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MS_ITER;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_pt = 1'b1;
          state_next  = CARD_SQ;
        end
      end
      CARD_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_CARD_SQ;
        state_next    = CARD_SQ_WAIT;
      end
      CARD_SQ_WAIT: begin
        if (sts.mul_done) begin
          state_next = CARD_SUM;
        end
      end
      CARD_SUM: begin
        cmd.card_sum = 1'b1;
        state_next   = CARD_PROD;
      end
      CARD_PROD: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_CARD_PROD;
        state_next    = CARD_PROD_WAIT;
      end
      CARD_PROD_WAIT: begin
        if (sts.mul_done) begin
          state_next = CARD_CHECK;
        end
      end
      CARD_CHECK: begin
        if (sts.in_set) begin
          cmd.n_to_max = 1'b1;
          state_next   = FINISH;
        end else begin
          cmd.loop_init = 1'b1;
          state_next    = ITER_MUL;
        end
      end
      ITER_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_ITER;
        state_next    = ITER_WAIT;
      end
      ITER_WAIT: begin
        if (sts.mul_done) begin
          state_next = ITER_TEST;
        end
      end
      ITER_TEST: begin
        if (sts.keep_going) begin
          cmd.iter_step = 1'b1;
          state_next    = ITER_MUL;
        end else begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/mandelbrot_escape_count.sv
// top level of the escape counter: controller, datapath and channel hookup
//
//   channel   dir  payload                   transaction when
//   point     in   c_real, c_imag (Q4.28)    point.valid && point.ready
//   result    out  iter_count                result.valid && result.ready
//   cfg       in   cfg_wdata (max_iter)      cfg_we
//
// one point at a time; a point that falls in the cardioid or the period-2 bulb
// skips the iteration loop and reports max_iter
// each iteration is three products, one in each of the three multiplier units
// the result register lets the next point start while a count waits
// reset is synchronous; max_iter returns to 256
`default_nettype none

module mandelbrot_escape_count import mec_pkg::*; #(
  parameter int ITER_WIDTH = DEF_ITER_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  mec_point_if.sink             point,
  mec_count_if.source           result,
  input  logic                  cfg_we,
  input  logic [ITER_WIDTH-1:0] cfg_wdata
);

  mec_cmd_t cmd;
  mec_sts_t sts;

  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mec_datapath #(
    .ITER_WIDTH (ITER_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .c_real     (point.c_real),
    .c_imag     (point.c_imag),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .iter_count (result.iter_count)
  );

endmodule

`default_nettype wire

FILE: design/mec_checker.sv
// port-level checks for the escape counter, bound to the top level
`default_nettype none

module mec_checker import mec_pkg::*; #(
  parameter int ITER_WIDTH = DEF_ITER_WIDTH
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  pt_valid,
  input logic                  pt_ready,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [ITER_WIDTH-1:0] res_count
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = pt_valid && pt_ready;
  assign out_acc = res_valid && res_ready;

  // points taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 2'd0)
    else $error("result shown with no point outstanding");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (pending == 2'd0 || pending == 2'd1))
    else $error("point taken while another is still in work");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_count))
    else $error("stalled result dropped or changed");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind mandelbrot_escape_count mec_checker #(
  .ITER_WIDTH (ITER_WIDTH)
) u_mec_checker (
  .clk       (clk),
  .rst       (rst),
  .pt_valid  (point.valid),
  .pt_ready  (point.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_count (result.iter_count)
);

`default_nettype wire
